### src/lcd_mode_line_timer_core_defines.svh
// Assertion macros used by the LCD mode and line timer RTL.
`ifndef LCD_MODE_LINE_TIMER_CORE_DEFINES_SVH
`define LCD_MODE_LINE_TIMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked property check that is disabled while reset is asserted.
`define LMT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lcd timer check failed");
// Implication form of the check above.
`define LMT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  `LMT_ASSERT(name, clk, rst_n, (ante) |-> (cons))
`else
`define LMT_ASSERT(name, clk, rst_n, prop)
`define LMT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif

`endif

### src/lcdmlt_pkg.sv
// Types and constants of the LCD mode and line timer.
`default_nettype none

package lcdmlt_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef enum logic [2:0] {
    REG_DISPLAY_ENABLE = 3'd0,
    REG_LINE_COMPARE   = 3'd1,
    REG_STAT_ENABLES   = 3'd2,
    REG_HBLANK_TICKS   = 3'd3,
    REG_VBLANK_TICKS   = 3'd4,
    REG_OAM_TICKS      = 3'd5,
    REG_XFER_TICKS     = 3'd6
  } reg_idx_e;

  localparam logic [7:0]  LAST_VISIBLE_LINE = 8'd143;
  localparam logic [7:0]  FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0]  LAST_LINE         = 8'd153;
  localparam logic [10:0] COUNTER_MAX       = 11'h7FF;

  localparam logic [9:0]  HBLANK_RST = 10'd204;
  localparam logic [9:0]  VBLANK_RST = 10'd456;
  localparam logic [9:0]  OAM_RST    = 10'd80;
  localparam logic [9:0]  XFER_RST   = 10'd172;

  // Bit positions inside stat_enables.
  localparam int unsigned STAT_EN_HBLANK = 0;
  localparam int unsigned STAT_EN_VBLANK = 1;
  localparam int unsigned STAT_EN_OAM    = 2;
  localparam int unsigned STAT_EN_COIN   = 3;

endpackage

`default_nettype wire

### src/lcd_mode_line_timer_core.sv
// LCD mode and line timer: tick accumulation, mode sequencing and interrupt requests.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-------------------------------------------
//   input     | in_valid_i / in_stall_o    | ticks_i
//   output    | out_valid_o / out_stall_i  | lcd_mode_o, line_o, coincidence_o,
//             |                            | vblank_irq_o, stat_irq_o, render_request_o
//   config    | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// Every accepted beat produces one result beat on the following cycle.
// One beat per cycle is sustained unless the output side stalls; the add, saturate and
// length compare sit between the timing state registers and the result register.
// The input stalls only while a result is held and the output side stalls.
// Reset puts the timer on line 0 in HBlank with a cleared counter and default lengths.
`default_nettype none

`include "lcd_mode_line_timer_core_defines.svh"

module lcd_mode_line_timer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       lcd_mode_o,
  output logic [7:0]       line_o,
  output logic             coincidence_o,
  output logic             vblank_irq_o,
  output logic             stat_irq_o,
  output logic             render_request_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lcdmlt_pkg::*;

  // Configuration registers.
  logic       display_enable_q;
  logic [7:0] line_compare_q;
  logic [3:0] stat_enables_q;
  logic [9:0] hblank_ticks_q;
  logic [9:0] vblank_ticks_q;
  logic [9:0] oam_ticks_q;
  logic [9:0] xfer_ticks_q;

  // Timing state.
  logic [10:0] counter_q, counter_d;
  lcd_mode_e   mode_q, mode_d;
  logic [7:0]  line_q, line_d;
  logic        coin_q, coin_d;

  // Result register.
  logic        out_valid_q;
  lcd_mode_e   res_mode_q;
  logic [7:0]  res_line_q;
  logic        res_coin_q;
  logic        res_vbl_q;
  logic        res_stat_q;
  logic        res_render_q;

  logic        in_acc;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;
  logic [11:0] sum;
  logic [10:0] counter_sat;
  logic [7:0]  line_inc;
  logic        vbl_irq;
  logic        stat_req;
  logic        render;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite;
  assign cfg_idx    = reg_idx_e'(paddr[4:2]);
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DISPLAY_ENABLE: prdata = {31'd0, display_enable_q};
      REG_LINE_COMPARE:   prdata = {24'd0, line_compare_q};
      REG_STAT_ENABLES:   prdata = {28'd0, stat_enables_q};
      REG_HBLANK_TICKS:   prdata = {22'd0, hblank_ticks_q};
      REG_VBLANK_TICKS:   prdata = {22'd0, vblank_ticks_q};
      REG_OAM_TICKS:      prdata = {22'd0, oam_ticks_q};
      REG_XFER_TICKS:     prdata = {22'd0, xfer_ticks_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_enable_q <= 1'b1;
      line_compare_q   <= '0;
      stat_enables_q   <= '0;
      hblank_ticks_q   <= HBLANK_RST;
      vblank_ticks_q   <= VBLANK_RST;
      oam_ticks_q      <= OAM_RST;
      xfer_ticks_q     <= XFER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DISPLAY_ENABLE: display_enable_q <= pwdata[0];
        REG_LINE_COMPARE:   line_compare_q   <= pwdata[7:0];
        REG_STAT_ENABLES:   stat_enables_q   <= pwdata[3:0];
        REG_HBLANK_TICKS:   hblank_ticks_q   <= pwdata[9:0];
        REG_VBLANK_TICKS:   vblank_ticks_q   <= pwdata[9:0];
        REG_OAM_TICKS:      oam_ticks_q      <= pwdata[9:0];
        REG_XFER_TICKS:     xfer_ticks_q     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum         = {1'b0, counter_q} + {4'd0, ticks_i};
    counter_sat = sum[11] ? COUNTER_MAX : sum[10:0];
    line_inc    = line_q + 8'd1;
    counter_d   = counter_sat;
    mode_d      = mode_q;
    line_d      = line_q;
    vbl_irq     = 1'b0;
    stat_req    = 1'b0;
    render      = 1'b0;

    unique case (mode_q)
      MODE_HBLANK: begin
        if (counter_sat >= {1'b0, hblank_ticks_q}) begin
          counter_d = '0;
          line_d    = line_inc;
          if (line_inc == FIRST_VBLANK_LINE) begin
            mode_d   = MODE_VBLANK;
            vbl_irq  = 1'b1;
            stat_req = stat_enables_q[STAT_EN_VBLANK];
          end else begin
            mode_d   = MODE_OAM;
            stat_req = stat_enables_q[STAT_EN_OAM];
          end
        end
      end
      MODE_VBLANK: begin
        if (counter_sat >= {1'b0, vblank_ticks_q}) begin
          counter_d = '0;
          line_d    = line_inc;
          // Past the last line the frame restarts on line zero.
          if (line_inc > LAST_LINE) begin
            mode_d   = MODE_OAM;
            stat_req = stat_enables_q[STAT_EN_OAM];
            line_d   = '0;
          end
        end
      end
      MODE_OAM: begin
        if (counter_sat >= {1'b0, oam_ticks_q}) begin
          counter_d = '0;
          mode_d    = MODE_XFER;
        end
      end
      MODE_XFER: begin
        if (counter_sat >= {1'b0, xfer_ticks_q}) begin
          counter_d = '0;
          mode_d    = MODE_HBLANK;
          stat_req  = stat_enables_q[STAT_EN_HBLANK];
          render    = 1'b1;
        end
      end
      default: ;
    endcase

    coin_d = (line_q == line_compare_q);
    if (coin_d && stat_enables_q[STAT_EN_COIN]) begin
      stat_req = 1'b1;
    end

    // Display disabled: counter and coincidence hold; line 0 in VBlank, no requests.
    if (!display_enable_q) begin
      counter_d = counter_q;
      mode_d    = MODE_VBLANK;
      line_d    = '0;
      coin_d    = coin_q;
      vbl_irq   = 1'b0;
      stat_req  = 1'b0;
      render    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      mode_q      <= MODE_HBLANK;
      line_q      <= '0;
      coin_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc | (out_valid_q & out_stall_i);
      if (in_acc) begin
        counter_q <= counter_d;
        mode_q    <= mode_d;
        line_q    <= line_d;
        coin_q    <= coin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_mode_q   <= mode_d;
      res_line_q   <= line_d;
      res_coin_q   <= coin_d;
      res_vbl_q    <= vbl_irq;
      res_stat_q   <= stat_req;
      res_render_q <= render;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign lcd_mode_o       = res_mode_q;
  assign line_o           = res_line_q;
  assign coincidence_o    = res_coin_q;
  assign vblank_irq_o     = res_vbl_q;
  assign stat_irq_o       = res_stat_q;
  assign render_request_o = res_render_q;

  `LMT_ASSERT(a_line_in_frame, clk_i, rst_ni, (line_q <= LAST_LINE))
  `LMT_ASSERT_IMP(a_render_enters_hblank, clk_i, rst_ni, out_valid_q && res_render_q,
    res_mode_q == MODE_HBLANK)
  `LMT_ASSERT_IMP(a_vblank_irq_line, clk_i, rst_ni, out_valid_q && res_vbl_q,
    res_mode_q == MODE_VBLANK && res_line_q == FIRST_VBLANK_LINE)
  `LMT_ASSERT(a_display_off_result, clk_i, rst_ni,
    (in_acc && !display_enable_q) |=> (res_line_q == 8'd0 && res_mode_q == MODE_VBLANK
      && !res_stat_q && !res_vbl_q && !res_render_q))

endmodule

`default_nettype wire
